// ===== rtl/wrp_pkg.sv =====
package wrp_pkg;

    localparam int TOTAL_BITS     = 22;
    localparam int WEIGHT_IN_BITS = 16;
    localparam int IDX_OUT_BITS   = 6;
    localparam int CNT_OUT_BITS   = 7;

    localparam logic [TOTAL_BITS-1:0] TOTAL_LIMIT = {TOTAL_BITS{1'b1}};

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_PICK  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef enum logic [2:0] {
        S_FETCH,
        S_DECODE,
        S_UPDATE,
        S_PRIME,
        S_SCAN,
        S_EMIT
    } step_t;

    typedef enum logic [2:0] {
        ACT_LATCH,
        ACT_CHECK,
        ACT_UPDATE,
        ACT_PRIME,
        ACT_SCAN,
        ACT_EMIT
    } act_t;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_ACCEPT,
        C_PICK,
        C_FAIL,
        C_DONE,
        C_OUT_FREE
    } cond_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        step_t jump;
        step_t next;
    } ctrl_t;

    typedef struct packed {
        logic is_pick;
        logic check_fail;
        logic scan_done;
    } dp_flags_t;

    typedef struct packed {
        logic in_accept;
        logic out_free;
    } io_flags_t;

    typedef struct packed {
        act_t act;
        logic ready;
    } seq_stat_t;

    // Control store: the step jumps to "jump" when its condition holds, else to "next".
    function automatic ctrl_t ucode_rom(input step_t step);
        ctrl_t word;
        case (step)
            S_FETCH:  word = '{ACT_LATCH,  C_ACCEPT,   S_DECODE, S_FETCH};
            S_DECODE: word = '{ACT_CHECK,  C_PICK,     S_PRIME,  S_UPDATE};
            S_UPDATE: word = '{ACT_UPDATE, C_ALWAYS,   S_EMIT,   S_EMIT};
            S_PRIME:  word = '{ACT_PRIME,  C_FAIL,     S_EMIT,   S_SCAN};
            S_SCAN:   word = '{ACT_SCAN,   C_DONE,     S_EMIT,   S_SCAN};
            S_EMIT:   word = '{ACT_EMIT,   C_OUT_FREE, S_FETCH,  S_EMIT};
            default:  word = '{ACT_LATCH,  C_ALWAYS,   S_FETCH,  S_FETCH};
        endcase
        return word;
    endfunction

endpackage

// ===== rtl/wrp_seq.sv =====
module wrp_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  wrp_pkg::dp_flags_t dp_flags,
    input  wrp_pkg::io_flags_t io_flags,
    output wrp_pkg::seq_stat_t seq_stat
);
    import wrp_pkg::*;

    step_t step_reg;
    step_t step_next;
    ctrl_t ctrl;
    logic  taken;

    always_comb
    begin
        ctrl = ucode_rom(step_reg);
        seq_stat.act = ctrl.act;
        seq_stat.ready = (step_reg == S_FETCH);
    end

    always_comb
    begin
        case (ctrl.cond)
            C_ALWAYS:   taken = 1'b1;
            C_ACCEPT:   taken = io_flags.in_accept;
            C_PICK:     taken = dp_flags.is_pick;
            C_FAIL:     taken = dp_flags.check_fail;
            C_DONE:     taken = dp_flags.scan_done;
            C_OUT_FREE: taken = io_flags.out_free;
            default:    taken = 1'b1;
        endcase
        step_next = taken ? ctrl.jump : ctrl.next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_FETCH;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ===== rtl/wrp_dp.sv =====
module wrp_dp #(
    parameter int MAX_ITEMS   = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  wrp_pkg::act_t                        act,
    input  logic                                 in_accept,
    input  logic [1:0]                           operation,
    input  logic [wrp_pkg::WEIGHT_IN_BITS-1:0]   weight,
    input  logic [wrp_pkg::TOTAL_BITS-1:0]       choice,
    output wrp_pkg::dp_flags_t                   dp_flags,
    output logic [$clog2(MAX_ITEMS)-1:0]         res_idx,
    output logic [1:0]                           res_status,
    output logic [$clog2(MAX_ITEMS+1)-1:0]       count,
    output logic [wrp_pkg::TOTAL_BITS-1:0]       total
);
    import wrp_pkg::*;

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W = ((WEIGHT_BITS > TOTAL_BITS) ? WEIGHT_BITS : TOTAL_BITS) + 1;

    logic [WEIGHT_BITS-1:0] mem [MAX_ITEMS];
    logic [WEIGHT_BITS-1:0] rdata_reg;

    logic [1:0]             op_reg;
    logic [WEIGHT_BITS-1:0] w_reg;
    logic [TOTAL_BITS-1:0]  choice_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [TOTAL_BITS-1:0]  total_reg;
    logic [TOTAL_BITS-1:0]  total_next;
    logic [TOTAL_BITS-1:0]  run_reg;
    logic [IDX_W-1:0]       addr_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [IDX_W-1:0]       res_idx_reg;
    logic [1:0]             res_status_reg;

    logic [SUM_W-1:0]       add_sum;
    logic                   add_ok;
    logic                   mem_we;
    logic [SUM_W-1:0]       scan_sum;
    logic                   scan_hit;
    logic                   scan_last;

    assign add_sum = SUM_W'(total_reg) + SUM_W'(w_reg);
    assign add_ok  = (count_reg != CNT_W'(MAX_ITEMS)) && (add_sum <= SUM_W'(TOTAL_LIMIT));
    assign mem_we  = (act == ACT_UPDATE) && (op_reg == OP_ADD) && add_ok;

    assign scan_sum  = SUM_W'(run_reg) + SUM_W'(rdata_reg);
    assign scan_hit  = SUM_W'(choice_reg) <= scan_sum;
    assign scan_last = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;

    assign dp_flags.is_pick    = (op_reg == OP_PICK);
    assign dp_flags.check_fail = (count_reg == '0) || (choice_reg == '0)
                                 || (choice_reg > total_reg);
    assign dp_flags.scan_done  = scan_hit || scan_last;

    assign res_idx    = res_idx_reg;
    assign res_status = res_status_reg;
    assign count      = count_reg;
    assign total      = total_reg;

    always_comb
    begin
        count_next = count_reg;
        total_next = total_reg;
        if (act == ACT_UPDATE)
        begin
            if (mem_we)
            begin
                count_next = count_reg + CNT_W'(1);
                total_next = add_sum[TOTAL_BITS-1:0];
            end
            else if (op_reg == OP_CLEAR)
            begin
                count_next = '0;
                total_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            total_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[IDX_W-1:0]] <= w_reg;
        end
        rdata_reg <= mem[addr_reg];
    end

    always_ff @(posedge clk)
    begin
        case (act)
            ACT_LATCH:
            begin
                if (in_accept)
                begin
                    op_reg     <= operation;
                    w_reg      <= WEIGHT_BITS'(weight);
                    choice_reg <= choice;
                end
            end
            ACT_CHECK:
            begin
                addr_reg <= '0;
                run_reg  <= '0;
            end
            ACT_UPDATE:
            begin
                if (op_reg == OP_ADD)
                begin
                    res_idx_reg    <= add_ok ? count_reg[IDX_W-1:0] : '0;
                    res_status_reg <= add_ok ? ST_OK : ST_FULL;
                end
                else
                begin
                    res_idx_reg    <= '0;
                    res_status_reg <= ST_OK;
                end
            end
            ACT_PRIME:
            begin
                addr_reg       <= addr_reg + IDX_W'(1);
                idx_reg        <= '0;
                res_idx_reg    <= '0;
                res_status_reg <= (count_reg == '0) ? ST_EMPTY : ST_RANGE;
            end
            ACT_SCAN:
            begin
                addr_reg <= addr_reg + IDX_W'(1);
                idx_reg  <= idx_reg + IDX_W'(1);
                run_reg  <= scan_sum[TOTAL_BITS-1:0];
                res_idx_reg    <= scan_hit ? idx_reg : '0;
                res_status_reg <= scan_hit ? ST_OK : ST_RANGE;
            end
            default:
            begin
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (total_reg == '0))
        else $error("empty table with nonzero total");

    a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("stored add did not advance the count");

    a_scan_hit: assert property (@(posedge clk) disable iff (!rst_n)
        ((act == ACT_SCAN) && scan_hit)
        |=> ((res_status_reg == ST_OK) && (res_idx_reg == $past(idx_reg))))
        else $error("scan hit not reported");
`endif

endmodule

// ===== rtl/weighted_random_pick.sv =====
// Weighted random pick: a table of item weights with roulette wheel selection.
// Input channel: in_valid/in_stall carry operation, weight and choice. An item
// is taken at a clock edge where in_valid is high and in_stall is low. An add
// appends a weight, a clear empties the table, a pick returns the index of the
// first item whose running weight sum reaches choice (1 to total_weight).
// Output channel: out_valid/out_stall carry item_index, status, item_count and
// total_weight; every input item gives exactly one result item.
// Operation: a small microcoded sequencer steps a datapath with a weight memory
// that has one write port and one read port. Add and clear pass through decode
// and update, and rejected picks through decode and prime, before the result is
// emitted; other picks then scan from item 0 up to the item they land on, and
// the scan reads one stored weight per cycle from the memory. The next item is
// taken only after the result enters the output register.
// A stalled result holds in the output register; the block finishes the
// following item and waits with it until the register frees up.
// Reset empties the table and clears the output channel; weight memory
// contents are not cleared and are never used before being written.
module weighted_random_pick #(
    parameter int MAX_ITEMS   = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           operation,
    input  logic [wrp_pkg::WEIGHT_IN_BITS-1:0]   weight,
    input  logic [wrp_pkg::TOTAL_BITS-1:0]       choice,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [wrp_pkg::IDX_OUT_BITS-1:0]     item_index,
    output logic [1:0]                           status,
    output logic [wrp_pkg::CNT_OUT_BITS-1:0]     item_count,
    output logic [wrp_pkg::TOTAL_BITS-1:0]       total_weight
);
    import wrp_pkg::*;

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    seq_stat_t             seq_stat;
    dp_flags_t             dp_flags;
    io_flags_t             io_flags;
    logic [IDX_W-1:0]      res_idx;
    logic [1:0]            res_status;
    logic [CNT_W-1:0]      count;
    logic [TOTAL_BITS-1:0] total;
    logic                  out_load;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [IDX_OUT_BITS-1:0] index_reg;
    logic [1:0]              status_reg;
    logic [CNT_OUT_BITS-1:0] count_reg;
    logic [TOTAL_BITS-1:0]   total_reg;

    assign in_stall           = !seq_stat.ready;
    assign io_flags.in_accept = in_valid && seq_stat.ready;
    assign io_flags.out_free  = !out_valid_reg || !out_stall;
    assign out_load           = (seq_stat.act == ACT_EMIT) && io_flags.out_free;

    wrp_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .dp_flags (dp_flags),
        .io_flags (io_flags),
        .seq_stat (seq_stat)
    );

    wrp_dp #(
        .MAX_ITEMS   (MAX_ITEMS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .act        (seq_stat.act),
        .in_accept  (io_flags.in_accept),
        .operation  (operation),
        .weight     (weight),
        .choice     (choice),
        .dp_flags   (dp_flags),
        .res_idx    (res_idx),
        .res_status (res_status),
        .count      (count),
        .total      (total)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            index_reg  <= IDX_OUT_BITS'(res_idx);
            status_reg <= res_status;
            count_reg  <= CNT_OUT_BITS'(count);
            total_reg  <= total;
        end
    end

    assign out_valid    = out_valid_reg;
    assign item_index   = index_reg;
    assign status       = status_reg;
    assign item_count   = count_reg;
    assign total_weight = total_reg;

endmodule
